### hdl/sra_pkg.sv
package sra_pkg;

   localparam int SRA_SYMBOLS    = 256;
   localparam int SRA_BYTE_W     = 8;
   localparam int SRA_ADDR_W     = $clog2(SRA_SYMBOLS);
   localparam int SRA_RANK_W     = 33;
   localparam int SRA_CHUNK_W    = 32;
   localparam int SRA_COUNT_BITS = 32;
   localparam int SRA_CSR_W      = 32;
   localparam int SRA_CSR_IDX_W  = 1;

   // Highest legal encoded byte value
   localparam logic [SRA_BYTE_W:0] SRA_BYTE_LIMIT = 9'd254;

   localparam logic [SRA_BYTE_W-1:0]  SRA_NUM_FILES_RST = 8'd1;
   localparam logic [SRA_CHUNK_W-1:0] SRA_CHUNK_LEN_RST = 32'd65536;

   // Register indexes
   localparam logic [SRA_CSR_IDX_W-1:0] CSR_NUM_FILES = 1'd0;
   localparam logic [SRA_CSR_IDX_W-1:0] CSR_CHUNK_LEN = 1'd1;

   typedef enum logic [1:0] {
      KIND_COUNT    = 2'd0,
      KIND_CLOSE    = 2'd1,
      KIND_MAP      = 2'd2,
      KIND_FILE_END = 2'd3
   } sra_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_LIMIT = 2'd1,
      STATUS_PHASE = 2'd2
   } sra_status_type;

   typedef enum logic [1:0] {
      SRA_IDLE,
      SRA_COUNT,
      SRA_MAP,
      SRA_CLOSE
   } sra_state_type;

   typedef struct packed {
      sra_kind_type          kind;
      logic [SRA_BYTE_W-1:0] data_byte;
   } sra_req_type;

   typedef struct packed {
      logic signed [SRA_RANK_W-1:0] rank;
      logic [SRA_BYTE_W-1:0]        code;
      logic                         chunk_end;
      sra_status_type               status;
      logic [SRA_BYTE_W-1:0]        bad_byte;
   } sra_rsp_type;

endpackage

### hdl/symbol_rank_assigner_top.sv
// Channel | Ports                        | Direction | Handshake
// --------+------------------------------+-----------+-------------------------------
// request | start, busy, req_data        | in        | taken when start && !busy
// result  | rsp_valid, rsp_data          | out       | one-cycle strobe, no stall
// config  | csr_we, csr_index, csr_wdata | in        | written when csr_we is high
//
// Count and map items make one histogram RAM read, then the write-back or
// the answer. Close sweeps the 256 RAM entries with read and write one
// entry apart. Wrong-phase and file-end items are answered from the idle
// state. Every item yields exactly one result. Reset is synchronous;
// per-entry valid bits make the RAM read as zero after reset, so no
// clearing pass is needed. The result side cannot stall.
module symbol_rank_assigner_top
   import sra_pkg::*;
#(
   parameter int COUNT_BITS = SRA_COUNT_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  sra_req_type              req_data,
   output logic                     rsp_valid,
   output sra_rsp_type              rsp_data,
   input  logic                     csr_we,
   input  logic [SRA_CSR_IDX_W-1:0] csr_index,
   input  logic [SRA_CSR_W-1:0]     csr_wdata
);

   sra_state_type state_ff, state_in;

   logic [SRA_BYTE_W-1:0]  nf_ff;
   logic [SRA_CHUNK_W-1:0] csize_ff;

   logic                   phase_ff, phase_in;
   logic [SRA_BYTE_W-1:0]  fidx_ff, fidx_in;
   logic [SRA_CHUNK_W-1:0] cpos_ff, cpos_in;
   logic [SRA_BYTE_W-1:0]  held_ff, held_in;
   logic [SRA_ADDR_W:0]    rcnt_ff, rcnt_in;
   logic                   wvld_ff, wvld_in;
   logic [SRA_ADDR_W-1:0]  widx_ff, widx_in;
   logic [COUNT_BITS-1:0]  run_ff, run_in;
   logic                   found_ff, found_in;
   logic [SRA_BYTE_W-1:0]  bad_ff, bad_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   sra_rsp_type            rsp_ff, rsp_in;

   logic [SRA_SYMBOLS-1:0] vbit_ff;
   logic                   vrd_ff;

   logic                  accept;
   logic                  mem_rd_en, mem_wr_en;
   logic [SRA_ADDR_W-1:0] mem_rd_addr, mem_wr_addr;
   logic [COUNT_BITS-1:0] mem_wr_data, mem_rd_data, cur_cnt;

   logic [SRA_RANK_W+COUNT_BITS-1:0] rank_wide;
   logic                             chunk_force, chunk_end;
   logic [SRA_CHUNK_W:0]             chunk_next;
   logic                             last_file, over_limit;

   assign busy   = (state_ff != SRA_IDLE);
   assign accept = start && !busy;

   sra_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (SRA_SYMBOLS)
   ) u_bins (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Entry never written reads as zero
   assign cur_cnt   = vrd_ff ? mem_rd_data : '0;
   assign rank_wide = {{SRA_RANK_W{1'b0}}, cur_cnt};

   // Chunk position step
   assign chunk_next = {1'b0, cpos_ff} + {{SRA_CHUNK_W{1'b0}}, 1'b1};
   assign chunk_end  = chunk_force || (chunk_next >= {1'b0, csize_ff});
   assign last_file  = (fidx_ff == (nf_ff - 8'd1));
   assign over_limit = ({1'b0, widx_ff} + {1'b0, nf_ff}) > SRA_BYTE_LIMIT;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SRA_IDLE: begin
            if (accept) begin
               unique case (req_data.kind)
                  KIND_COUNT:    state_in = phase_ff ? SRA_IDLE : SRA_COUNT;
                  KIND_CLOSE:    state_in = phase_ff ? SRA_IDLE : SRA_CLOSE;
                  KIND_MAP:      state_in = phase_ff ? SRA_MAP : SRA_IDLE;
                  KIND_FILE_END: state_in = SRA_IDLE;
               endcase
            end
         end
         SRA_COUNT: state_in = SRA_IDLE;
         SRA_MAP:   state_in = SRA_IDLE;
         SRA_CLOSE: begin
            if (wvld_ff && (widx_ff == SRA_ADDR_W'(SRA_SYMBOLS - 1))) begin
               state_in = SRA_IDLE;
            end
         end
      endcase
   end

   // Datapath and outputs
   always_comb begin
      mem_rd_en    = 1'b0;
      mem_rd_addr  = held_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = held_ff;
      mem_wr_data  = '0;
      chunk_force  = 1'b0;
      held_in      = held_ff;
      phase_in     = phase_ff;
      fidx_in      = fidx_ff;
      cpos_in      = cpos_ff;
      rcnt_in      = rcnt_ff;
      wvld_in      = 1'b0;
      widx_in      = widx_ff;
      run_in       = run_ff;
      found_in     = found_ff;
      bad_in       = bad_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      unique case (state_ff)
         SRA_IDLE: begin
            if (accept) begin
               held_in     = req_data.data_byte;
               mem_rd_en   = 1'b1;
               mem_rd_addr = req_data.data_byte;
               unique case (req_data.kind)
                  KIND_COUNT: begin
                     if (phase_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STATUS_PHASE;
                     end
                  end
                  KIND_CLOSE: begin
                     if (phase_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STATUS_PHASE;
                     end else begin
                        rcnt_in  = '0;
                        run_in   = COUNT_BITS'(nf_ff);
                        found_in = 1'b0;
                        bad_in   = '0;
                     end
                  end
                  KIND_MAP: begin
                     if (!phase_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STATUS_PHASE;
                     end
                  end
                  KIND_FILE_END: begin
                     rsp_valid_in = 1'b1;
                     if (!phase_ff) begin
                        rsp_in.status = STATUS_PHASE;
                     end else begin
                        chunk_force      = last_file;
                        rsp_in.rank      = SRA_RANK_W'(0) - SRA_RANK_W'(fidx_ff);
                        rsp_in.code      = fidx_ff;
                        rsp_in.chunk_end = chunk_end;
                        cpos_in          = chunk_end ? '0 : chunk_next[SRA_CHUNK_W-1:0];
                        fidx_in          = fidx_ff + 8'd1;
                     end
                  end
               endcase
            end
         end
         SRA_COUNT: begin
            // Write back the incremented count
            mem_wr_en    = 1'b1;
            mem_wr_data  = cur_cnt + COUNT_BITS'(1);
            rsp_valid_in = 1'b1;
         end
         SRA_MAP: begin
            rsp_valid_in     = 1'b1;
            rsp_in.rank      = rank_wide[SRA_RANK_W-1:0];
            rsp_in.code      = nf_ff + held_ff;
            rsp_in.chunk_end = chunk_end;
            cpos_in          = chunk_end ? '0 : chunk_next[SRA_CHUNK_W-1:0];
         end
         SRA_CLOSE: begin
            // Issue the next read one entry ahead of the write
            if (!rcnt_ff[SRA_ADDR_W]) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = rcnt_ff[SRA_ADDR_W-1:0];
               rcnt_in     = rcnt_ff + 1'b1;
               wvld_in     = 1'b1;
               widx_in     = rcnt_ff[SRA_ADDR_W-1:0];
            end
            // Replace the count by its starting rank
            if (wvld_ff) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = widx_ff;
               mem_wr_data = run_ff;
               run_in      = run_ff + cur_cnt;
               if (!found_ff && (cur_cnt != '0) && over_limit) begin
                  found_in = 1'b1;
                  bad_in   = widx_ff;
               end
               if (widx_ff == SRA_ADDR_W'(SRA_SYMBOLS - 1)) begin
                  phase_in        = 1'b1;
                  rsp_valid_in    = 1'b1;
                  rsp_in.status   = found_in ? STATUS_LIMIT : STATUS_OK;
                  rsp_in.bad_byte = bad_in;
               end
            end
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SRA_IDLE;
         phase_ff     <= 1'b0;
         fidx_ff      <= '0;
         cpos_ff      <= '0;
         wvld_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         vbit_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         fidx_ff      <= fidx_in;
         cpos_ff      <= cpos_in;
         wvld_ff      <= wvld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (mem_wr_en) begin
            vbit_ff[mem_wr_addr] <= 1'b1;
         end
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         nf_ff    <= SRA_NUM_FILES_RST;
         csize_ff <= SRA_CHUNK_LEN_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NUM_FILES: nf_ff    <= csr_wdata[SRA_BYTE_W-1:0];
            CSR_CHUNK_LEN: csize_ff <= csr_wdata[SRA_CHUNK_W-1:0];
            default: ;
         endcase
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      held_ff  <= held_in;
      rcnt_ff  <= rcnt_in;
      widx_ff  <= widx_in;
      run_ff   <= run_in;
      found_ff <= found_in;
      bad_ff   <= bad_in;
      rsp_ff   <= rsp_in;
      if (mem_rd_en) begin
         vrd_ff <= vbit_ff[mem_rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A counting item answers after passing the SRA_COUNT state and the result register
   a_count_latency: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.kind == KIND_COUNT) && !phase_ff)
      |=> !rsp_valid_ff ##1 rsp_valid_ff)
      else $error("count item result not on time");

   // Mapping phase is left only by reset
   a_phase_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff |=> phase_ff)
      else $error("mapping phase dropped");

   // The histogram is written only by a count update or the close sweep
   a_write_source: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (state_ff == SRA_COUNT) || ((state_ff == SRA_CLOSE) && wvld_ff))
      else $error("unexpected histogram write");

   // The close sweep never writes the entry it is reading
   a_sweep_hazard: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == SRA_CLOSE) && mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
      else $error("close sweep read and write collide");

endmodule

### hdl/sra_ram.sv
module sra_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### tb/sra_rank_check.sv
`timescale 1ns / 100ps

module sra_rank_check
   import sra_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     busy,
   input  sra_req_type              req_data,
   input  logic                     rsp_valid,
   input  sra_rsp_type              rsp_data,
   input  logic                     csr_we,
   input  logic [SRA_CSR_IDX_W-1:0] csr_index,
   input  logic [SRA_CSR_W-1:0]     csr_wdata,
   output int                       mismatch_count,
   output int                       pending_count,
   output int                       result_count,
   output int                       chunk_end_count
);

   // Local copy of the histogram, phase, sentinel index and chunk fill
   logic [SRA_COUNT_BITS-1:0] bin_count [SRA_SYMBOLS];
   logic                      in_mapping;
   logic [SRA_BYTE_W-1:0]     file_idx;
   logic [SRA_CHUNK_W-1:0]    chunk_pos;
   logic [SRA_BYTE_W-1:0]     num_files;
   logic [SRA_CHUNK_W-1:0]    chunk_limit;

   // Results owed by the block, oldest first
   sra_rsp_type ranks_due [$];

   // Advance the chunk fill; return 1 when this symbol closes the chunk
   function automatic logic close_chunk(input logic force_end);
      logic [SRA_CHUNK_W:0] nxt;
      nxt = {1'b0, chunk_pos} + 1'b1;
      if (force_end || nxt >= {1'b0, chunk_limit}) begin
         chunk_pos = '0;
         return 1'b1;
      end
      chunk_pos = nxt[SRA_CHUNK_W-1:0];
      return 1'b0;
   endfunction

   // Apply one item to the local state and return the result it owes
   function automatic sra_rsp_type compute_rank_result(input sra_req_type item);
      sra_rsp_type               res;
      logic [SRA_COUNT_BITS-1:0] running;
      logic [SRA_COUNT_BITS-1:0] cnt;
      logic                      found;
      logic                      last_file;
      res   = '0;
      found = 1'b0;
      case (item.kind) inside
         KIND_COUNT, KIND_CLOSE: begin
            if (in_mapping) begin
               res.status = STATUS_PHASE;
            end else if (item.kind == KIND_COUNT) begin
               bin_count[item.data_byte] = bin_count[item.data_byte] + 1'b1;
            end else begin
               // Turn counts into starting ranks, flag the lowest byte over the limit
               running = SRA_COUNT_BITS'(num_files);
               for (int v = 0; v < SRA_SYMBOLS; v++) begin
                  cnt = bin_count[v];
                  if (!found && cnt != 0 && (v + int'(num_files)) > int'(SRA_BYTE_LIMIT)) begin
                     found        = 1'b1;
                     res.bad_byte = SRA_BYTE_W'(v);
                  end
                  bin_count[v] = running;
                  running      = running + cnt;
               end
               if (found) res.status = STATUS_LIMIT;
               in_mapping = 1'b1;
            end
         end
         KIND_MAP: begin
            if (!in_mapping) begin
               res.status = STATUS_PHASE;
            end else begin
               res.rank      = SRA_RANK_W'(bin_count[item.data_byte]);
               res.code      = num_files + item.data_byte;
               res.chunk_end = close_chunk(1'b0);
            end
         end
         default: begin
            if (!in_mapping) begin
               res.status = STATUS_PHASE;
            end else begin
               last_file     = (file_idx == SRA_BYTE_W'(num_files - 1'b1));
               res.rank      = SRA_RANK_W'(0) - SRA_RANK_W'(file_idx);
               res.code      = file_idx;
               res.chunk_end = close_chunk(last_file);
               file_idx      = file_idx + 1'b1;
            end
         end
      endcase
      return res;
   endfunction

   task automatic report_miss(input string why, input sra_rsp_type want,
                              input sra_rsp_type got);
      if (mismatch_count < 10) begin
         $display("%s: exp rank %0d code %h end %b status %0d bad %h", why,
                  want.rank, want.code, want.chunk_end, want.status, want.bad_byte);
         $display("   got rank %0d code %h end %b status %0d bad %h",
                  got.rank, got.code, got.chunk_end, got.status, got.bad_byte);
      end
      mismatch_count++;
   endtask

   // Track writes and items, then match each result against the oldest item
   always @(posedge clock) begin : watch
      sra_rsp_type want;
      if (reset) begin
         foreach (bin_count[i]) bin_count[i] = '0;
         in_mapping  = 1'b0;
         file_idx    = '0;
         chunk_pos   = '0;
         num_files   = SRA_NUM_FILES_RST;
         chunk_limit = SRA_CHUNK_LEN_RST;
         ranks_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_NUM_FILES: num_files   = csr_wdata[SRA_BYTE_W-1:0];
               CSR_CHUNK_LEN: chunk_limit = csr_wdata[SRA_CHUNK_W-1:0];
               default: ;
            endcase
         end
         if (start && !busy) ranks_due.push_back(compute_rank_result(req_data));
         if (rsp_valid) begin
            result_count++;
            if (rsp_data.chunk_end === 1'b1) chunk_end_count++;
            if (ranks_due.size() == 0) begin
               report_miss("result with no item outstanding", '0, rsp_data);
            end else begin
               want = ranks_due.pop_front();
               if (rsp_data.rank !== want.rank || rsp_data.code !== want.code ||
                   rsp_data.chunk_end !== want.chunk_end ||
                   rsp_data.status !== want.status || rsp_data.bad_byte !== want.bad_byte)
                  report_miss("rank result mismatch", want, rsp_data);
            end
         end
      end
      pending_count = ranks_due.size();
   end

endmodule

### tb/symbol_rank_assigner_top_test.sv
`timescale 1ns / 100ps

module symbol_rank_assigner_top_test
   import sra_pkg::*;
();

   localparam int COUNT_ITEMS   = 350;
   localparam int MAP_SEGMENTS  = 8;
   localparam int SEGMENT_ITEMS = 100;
   localparam int ITEM_TARGET   = 1170;
   localparam int CYCLE_LIMIT   = 400000;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     start;
   logic                     busy;
   sra_req_type              req_data;
   logic                     rsp_valid;
   sra_rsp_type              rsp_data;
   logic                     csr_we;
   logic [SRA_CSR_IDX_W-1:0] csr_index;
   logic [SRA_CSR_W-1:0]     csr_wdata;

   int mismatch_count;
   int pending_count;
   int result_count;
   int chunk_end_count;

   int   cycle_count;
   int   items_sent;
   int   sentinels_sent;
   int   sender_idle_pct;
   logic mapping_entered;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   symbol_rank_assigner_top u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sra_rank_check u_check (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_data        (rsp_data),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .pending_count   (pending_count),
      .result_count    (result_count),
      .chunk_end_count (chunk_end_count)
   );

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Present one item after a random gap and hold it until taken
   task automatic send_item(input sra_kind_type k, input logic [SRA_BYTE_W-1:0] value);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= '{kind: k, data_byte: value};
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
      if (mapping_entered && k == KIND_FILE_END) sentinels_sent++;
      if (k == KIND_CLOSE) mapping_entered = 1'b1;
      if (items_sent >= 2 * ITEM_TARGET / 3) sender_idle_pct = 0;
      else if (items_sent >= ITEM_TARGET / 3) sender_idle_pct = 53;
      else sender_idle_pct = 30;
   endtask

   // Drop start and hold off until every result is back
   task automatic drain_block();
      @(negedge clock);
      start <= 1'b0;
      while (pending_count != 0 || busy) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [SRA_CSR_IDX_W-1:0] idx,
                            input logic [SRA_CSR_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Pick a file count whose last sentinel falls shortly ahead
   function automatic logic [SRA_BYTE_W-1:0] near_last_file();
      int nf;
      nf = (sentinels_sent + $urandom_range(24, 1)) % 256;
      if (nf < 1) nf = 1;
      if (nf > 254) nf = 254;
      return SRA_BYTE_W'(nf);
   endfunction

   initial begin
      int                     r;
      logic [SRA_BYTE_W-1:0]  nf;
      logic [SRA_CHUNK_W-1:0] csize;
      reset           = 1'b1;
      start           = 1'b0;
      req_data        = '0;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      sender_idle_pct = 30;
      mapping_entered = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_reg(CSR_NUM_FILES, 32'd1);
      write_reg(CSR_CHUNK_LEN, 32'd257);

      // Counting phase: wrong-phase items, byte extremes, then random items, mostly counts
      send_item(KIND_MAP, 8'h00);
      send_item(KIND_FILE_END, 8'hFF);
      send_item(KIND_COUNT, 8'h00);
      send_item(KIND_COUNT, 8'hFF);
      send_item(KIND_COUNT, 8'hFF);
      send_item(KIND_COUNT, 8'h55);
      send_item(KIND_COUNT, 8'hAA);
      send_item(KIND_COUNT, 8'h01);
      send_item(KIND_COUNT, 8'hFE);
      for (int i = 0; i < COUNT_ITEMS; i++) begin
         r = $urandom_range(99);
         if (r < 88) send_item(KIND_COUNT, SRA_BYTE_W'($urandom_range(255)));
         else if (r < 94) send_item(KIND_MAP, SRA_BYTE_W'($urandom_range(255)));
         else send_item(KIND_FILE_END, SRA_BYTE_W'($urandom_range(255)));
      end

      // Close with a file count that sets the byte limit
      drain_block();
      case ($urandom_range(2))
         0:       nf = 8'd1;
         1:       nf = 8'd254;
         default: nf = SRA_BYTE_W'($urandom_range(254, 1));
      endcase
      write_reg(CSR_NUM_FILES, {24'd0, nf});
      send_item(KIND_CLOSE, SRA_BYTE_W'($urandom_range(255)));

      // Mapping phase: wrong-phase items, code wrap, first file as the last one
      drain_block();
      write_reg(CSR_NUM_FILES, 32'd1);
      send_item(KIND_COUNT, 8'h10);
      send_item(KIND_CLOSE, 8'h00);
      send_item(KIND_MAP, 8'h00);
      send_item(KIND_MAP, 8'hFF);
      send_item(KIND_MAP, 8'hAA);
      send_item(KIND_MAP, 8'h55);
      send_item(KIND_FILE_END, 8'h00);
      send_item(KIND_FILE_END, 8'hFF);
      send_item(KIND_FILE_END, 8'h00);

      // Random mapping in segments, each with its own settings
      for (int seg = 0; seg < MAP_SEGMENTS; seg++) begin
         drain_block();
         case (seg)
            0:       nf = 8'd1;
            1:       nf = 8'd254;
            default: nf = near_last_file();
         endcase
         case (seg % 4)
            0:       csize = 32'd257;
            1:       csize = SRA_CHUNK_W'($urandom_range(600, 257));
            2:       csize = 32'hFFFF_FFFF;
            default: csize = 32'd258;
         endcase
         write_reg(CSR_NUM_FILES, {24'd0, nf});
         write_reg(CSR_CHUNK_LEN, csize);
         for (int i = 0; i < SEGMENT_ITEMS; i++) begin
            r = $urandom_range(99);
            if (r < 57) send_item(KIND_MAP, SRA_BYTE_W'($urandom_range(255)));
            else if (r < 90) send_item(KIND_FILE_END, SRA_BYTE_W'($urandom_range(255)));
            else if (r < 95) send_item(KIND_COUNT, SRA_BYTE_W'($urandom_range(255)));
            else send_item(KIND_CLOSE, SRA_BYTE_W'($urandom_range(255)));
         end
      end

      // Wait out the last results, then give the verdict
      drain_block();
      repeat (20) @(negedge clock);
      $display("sent %0d items through counting, close and mapping, %0d of them sentinels",
               items_sent, sentinels_sent);
      $display("checked %0d results, %0d closing a chunk", result_count, chunk_end_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

### symbol_rank_assigner_top.f
hdl/sra_pkg.sv
hdl/sra_ram.sv
hdl/symbol_rank_assigner_top.sv
tb/sra_rank_check.sv
tb/symbol_rank_assigner_top_test.sv
